// ===== rtl/decimal_scale_align_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the decimal scale alignment unit
// Short forms for clocked, reset-qualified properties.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_SCALE_ALIGN_UNIT_MACROS_SVH
`define DECIMAL_SCALE_ALIGN_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define DSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define DSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dsa_pkg.sv =====
// ---------------------------------------------------------------------------
// dsa_pkg
// Types and constants shared by the decimal scale alignment unit.
// ---------------------------------------------------------------------------
package dsa_pkg;

    localparam int MAG_W      = 96;
    localparam int WIDE_W     = MAG_W + 4;
    localparam int SCALE_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHUNK_W    = 24;
    localparam int NUM_CHUNKS = MAG_W / CHUNK_W;
    localparam int IDX_W      = $clog2(NUM_CHUNKS);
    localparam int CUR_W      = DIGIT_W + CHUNK_W;
    localparam int RECIP_W    = 32;
    localparam int PROD_W     = CUR_W + RECIP_W;
    localparam int RECIP_SHIFT = 35;

    // floor(x * RECIP_TEN / 2^35) == x / 10 for every x below 2^32
    localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam logic [DIGIT_W-1:0] ROUND_DIGIT = 4'd5;

    localparam int IN_W  = 208;
    localparam int OUT_W = 200;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_RND,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ALU_MUL10,
        ALU_DIV,
        ALU_INC
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [IDX_W-1:0]   idx;
        logic [DIGIT_W-1:0] rem_in;
        logic               inc;
    } alu_ctrl_t;

    typedef struct packed {
        logic               ovf;
        logic [DIGIT_W-1:0] rem_out;
    } alu_stat_t;

endpackage

// ===== rtl/dsa_alu.sv =====
// ---------------------------------------------------------------------------
// dsa_alu
// Shared step unit: times ten, one chunk of a divide by ten, or increment.
// ---------------------------------------------------------------------------
module dsa_alu
(
    input  dsa_pkg::alu_ctrl_t         ctrl,
    input  logic [dsa_pkg::MAG_W-1:0]  operand,
    output logic [dsa_pkg::MAG_W-1:0]  result,
    output dsa_pkg::alu_stat_t         stat
);
    import dsa_pkg::*;

    logic [WIDE_W-1:0]  add_a;
    logic [WIDE_W-1:0]  add_b;
    logic [WIDE_W-1:0]  sum;
    logic [CHUNK_W-1:0] chunk;
    logic [CUR_W-1:0]   cur;
    logic [PROD_W-1:0]  prod;
    logic [CHUNK_W-1:0] quot;
    logic [CUR_W-1:0]   quot_x10;
    logic [CUR_W-1:0]   rem_full;

    // one wide adder serves both the times-ten step and the rounding increment
    always_comb
    begin
        if (ctrl.op == ALU_MUL10)
        begin
            add_a = {1'b0, operand, 3'b000};
            add_b = {3'b000, operand, 1'b0};
        end
        else
        begin
            add_a = {4'b0000, operand};
            add_b = {{(WIDE_W-1){1'b0}}, ctrl.inc};
        end
    end

    assign sum = add_a + add_b;

    // chunk divide: remainder of the chunk above sits on top, so cur < 10 * 2^24
    assign chunk    = operand[ctrl.idx*CHUNK_W +: CHUNK_W];
    assign cur      = {ctrl.rem_in, chunk};
    assign prod     = PROD_W'(cur) * PROD_W'(RECIP_TEN);
    assign quot     = prod[RECIP_SHIFT +: CHUNK_W];
    assign quot_x10 = (CUR_W'(quot) << 3) + (CUR_W'(quot) << 1);
    assign rem_full = cur - quot_x10;

    always_comb
    begin
        result       = operand;
        stat.ovf     = 1'b0;
        stat.rem_out = rem_full[DIGIT_W-1:0];
        unique case (ctrl.op)
            ALU_MUL10:
            begin
                result   = sum[MAG_W-1:0];
                stat.ovf = |sum[WIDE_W-1:MAG_W];
            end
            ALU_DIV:
            begin
                result[ctrl.idx*CHUNK_W +: CHUNK_W] = quot;
            end
            ALU_INC:
            begin
                result = sum[MAG_W-1:0];
            end
            default:
            begin
                result = operand;
            end
        endcase
    end

endmodule

// ===== rtl/decimal_scale_align_unit.sv =====
// Each item is aligned by m times-ten steps and d divide-by-ten steps, m+d at
// most 31. Each divide step is four 24-bit chunk passes through the shared
// unit's reciprocal multiplier plus one rounding increment. A new item is
// taken only after the last result is written to the output register; the
// next is taken while a result waits at the output.
// Reset (rst_n low, asynchronous) empties the output register and idles the sequencer.
// ---------------------------------------------------------------------------
// decimal_scale_align_unit
// Brings two 96-bit decimal magnitudes to a common scale using one shared unit.
// ---------------------------------------------------------------------------
module decimal_scale_align_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // first_low, first_high, first_scale, second_low, second_high, second_scale
    input  logic [dsa_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_first_low, out_first_high, out_second_low, out_second_high, common_scale
    output logic [dsa_pkg::OUT_W-1:0]   m_tdata
);
    import dsa_pkg::*;

    state_t               state_reg, state_next;
    logic [MAG_W-1:0]     up_reg, up_next;
    logic [MAG_W-1:0]     down_reg, down_next;
    logic [SCALE_W-1:0]   s_up_reg, s_up_next;
    logic [SCALE_W-1:0]   s_down_reg, s_down_next;
    logic                 first_up_reg, first_up_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [DIGIT_W-1:0]   rem_reg, rem_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    logic [MAG_W-1:0]     in_first;
    logic [MAG_W-1:0]     in_second;
    logic [SCALE_W-1:0]   in_first_scale;
    logic [SCALE_W-1:0]   in_second_scale;
    logic                 in_first_up;
    logic [MAG_W-1:0]     alu_operand;
    logic [MAG_W-1:0]     alu_result;
    alu_ctrl_t            alu_ctrl;
    alu_stat_t            alu_stat;
    logic                 round_up;
    logic [SCALE_W-1:0]   s_down_dec;
    logic [MAG_W-1:0]     res_first;
    logic [MAG_W-1:0]     res_second;

    assign in_first        = s_tdata[95:0];
    assign in_first_scale  = s_tdata[100:96];
    assign in_second       = s_tdata[196:101];
    assign in_second_scale = s_tdata[201:197];
    assign in_first_up     = !(in_first_scale > in_second_scale);

    // half rounds up only onto an odd kept digit
    assign round_up   = (rem_reg > ROUND_DIGIT) || ((rem_reg == ROUND_DIGIT) && down_reg[0]);
    assign s_down_dec = s_down_reg - SCALE_W'(1);

    assign res_first  = first_up_reg ? up_reg : down_reg;
    assign res_second = first_up_reg ? down_reg : up_reg;

    assign alu_operand = (state_reg == ST_MUL) ? up_reg : down_reg;

    dsa_alu u_alu
    (
        .ctrl    (alu_ctrl),
        .operand (alu_operand),
        .result  (alu_result),
        .stat    (alu_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg       <= up_next;
        down_reg     <= down_next;
        s_up_reg     <= s_up_next;
        s_down_reg   <= s_down_next;
        first_up_reg <= first_up_next;
        idx_reg      <= idx_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        s_up_next      = s_up_reg;
        s_down_next    = s_down_reg;
        first_up_next  = first_up_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        alu_ctrl.op     = ALU_MUL10;
        alu_ctrl.idx    = idx_reg;
        alu_ctrl.rem_in = rem_reg;
        alu_ctrl.inc    = round_up;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    first_up_next = in_first_up;
                    up_next       = in_first_up ? in_first : in_second;
                    down_next     = in_first_up ? in_second : in_first;
                    s_up_next     = in_first_up ? in_first_scale : in_second_scale;
                    s_down_next   = in_first_up ? in_second_scale : in_first_scale;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                alu_ctrl.op = ALU_MUL10;
                if (s_up_reg < s_down_reg)
                begin
                    if (!alu_stat.ovf)
                    begin
                        up_next   = alu_result;
                        s_up_next = s_up_reg + SCALE_W'(1);
                    end
                    else
                    begin
                        idx_next   = IDX_W'(NUM_CHUNKS - 1);
                        rem_next   = '0;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                // most significant chunk first, remainder carried downwards
                alu_ctrl.op = ALU_DIV;
                down_next   = alu_result;
                rem_next    = alu_stat.rem_out;
                if (idx_reg == '0)
                begin
                    state_next = ST_RND;
                end
                else
                begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_RND:
            begin
                alu_ctrl.op = ALU_INC;
                down_next   = alu_result;
                s_down_next = s_down_dec;
                idx_next    = IDX_W'(NUM_CHUNKS - 1);
                rem_next    = '0;
                state_next  = (s_up_reg < s_down_dec) ? ST_DIV : ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = {3'b000, s_down_reg, res_second, res_first};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/dsa_checker.sv =====
// ---------------------------------------------------------------------------
// dsa_checker
// Port-level checks for the decimal scale alignment unit, bound to the top.
// ---------------------------------------------------------------------------
`include "decimal_scale_align_unit_macros.svh"

module dsa_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [dsa_pkg::IN_W-1:0]    s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [dsa_pkg::OUT_W-1:0]   m_tdata
);
    import dsa_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // items taken in but not yet handed out
    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!in_xfer && out_xfer)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `DSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `DSA_ASSERT_SAME(a_no_invented, m_tvalid, pend_reg != 2'd0, "result without a pending item")
    `DSA_ASSERT_SAME(a_no_third, in_xfer, pend_reg != 2'd2, "input taken with two items outstanding")
    `DSA_ASSERT_NEXT(a_busy_after_take, in_xfer, !s_tready, "ready straight after an input transfer")

endmodule

bind decimal_scale_align_unit dsa_checker u_dsa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/tb_decimal_scale_align_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_decimal_scale_align_unit
// Self-checking bench for the decimal scale alignment unit. A short list of
// directed operand pairs covers the extremes, ties and out-of-range scales.
// Random pairs follow under changing back-pressure. Every result transfer is
// compared field by field against a typed result or the scale-alignment model.
// ---------------------------------------------------------------------------
module tb_decimal_scale_align_unit;

    localparam int MAG_W          = dsa_pkg::MAG_W;
    localparam int SCALE_W        = dsa_pkg::SCALE_W;
    localparam int RANDOM_PER_RUN = 360;
    localparam int HOLD_OFF       = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [63:0]        first_low;
        logic [31:0]        first_high;
        logic [SCALE_W-1:0] first_scale;
        logic [63:0]        second_low;
        logic [31:0]        second_high;
        logic [SCALE_W-1:0] second_scale;
    } operand_pair_t;

    typedef struct {
        logic [63:0]        first_low;
        logic [31:0]        first_high;
        logic [63:0]        second_low;
        logic [31:0]        second_high;
        logic [SCALE_W-1:0] common_scale;
    } aligned_pair_t;

    typedef struct {
        operand_pair_t operands;
        bit            typed;
        aligned_pair_t result;
    } stimulus_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // first_low, first_high, first_scale, second_low, second_high, second_scale
    logic [dsa_pkg::IN_W-1:0] s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // out_first_low, out_first_high, out_second_low, out_second_high, common_scale
    logic [dsa_pkg::OUT_W-1:0] m_tdata;

    aligned_pair_t pending_alignments[$];
    stimulus_row_t directed_rows[$];
    int            mismatch_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_left = 0;
    int            quiet_cycles = 0;

    decimal_scale_align_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic operand_pair_t make_pair(input logic [MAG_W-1:0] first_mag,
                                                input logic [SCALE_W-1:0] first_scale,
                                                input logic [MAG_W-1:0] second_mag,
                                                input logic [SCALE_W-1:0] second_scale);
        operand_pair_t op;
        op.first_low    = first_mag[63:0];
        op.first_high   = first_mag[95:64];
        op.first_scale  = first_scale;
        op.second_low   = second_mag[63:0];
        op.second_high  = second_mag[95:64];
        op.second_scale = second_scale;
        return op;
    endfunction

    function automatic aligned_pair_t make_aligned(input logic [MAG_W-1:0] first_mag,
                                                   input logic [MAG_W-1:0] second_mag,
                                                   input logic [SCALE_W-1:0] scale);
        aligned_pair_t r;
        r.first_low    = first_mag[63:0];
        r.first_high   = first_mag[95:64];
        r.second_low   = second_mag[63:0];
        r.second_high  = second_mag[95:64];
        r.common_scale = scale;
        return r;
    endfunction

    // Lower-scale operand is scaled up while it fits, the other one is
    // divided with round-half-even on each dropped digit.
    function automatic aligned_pair_t align_scales(input operand_pair_t op);
        logic [MAG_W-1:0]   up_mag;
        logic [MAG_W-1:0]   down_mag;
        logic [MAG_W-1:0]   quot;
        logic [MAG_W+3:0]   prod;
        logic [3:0]         dropped;
        logic [SCALE_W-1:0] up_scale;
        logic [SCALE_W-1:0] down_scale;
        bit                 first_is_up;
        first_is_up = (op.first_scale <= op.second_scale);
        up_mag     = first_is_up ? {op.first_high, op.first_low}
                                 : {op.second_high, op.second_low};
        down_mag   = first_is_up ? {op.second_high, op.second_low}
                                 : {op.first_high, op.first_low};
        up_scale   = first_is_up ? op.first_scale : op.second_scale;
        down_scale = first_is_up ? op.second_scale : op.first_scale;
        while (up_scale < down_scale)
        begin
            prod = {4'b0, up_mag} * (MAG_W+4)'(10);
            if (prod[MAG_W+3:MAG_W] != 4'b0)
                break;
            up_mag   = prod[MAG_W-1:0];
            up_scale = up_scale + 1'b1;
        end
        while (up_scale < down_scale)
        begin
            quot    = down_mag / MAG_W'(10);
            dropped = 4'(down_mag - quot * MAG_W'(10));
            if (dropped > 4'd5 || (dropped == 4'd5 && quot[0]))
                quot = quot + 1'b1;
            down_mag   = quot;
            down_scale = down_scale - 1'b1;
        end
        if (first_is_up)
            return make_aligned(up_mag, down_mag, down_scale);
        else
            return make_aligned(down_mag, up_mag, down_scale);
    endfunction

    function automatic logic [MAG_W-1:0] random_mag();
        logic [MAG_W-1:0] m;
        m = {$urandom, $urandom, $urandom};
        case ($urandom_range(3))
            0: return m;
            1: return m >> $urandom_range(MAG_W-1);
            2: return m >> $urandom_range(MAG_W-1, 64);
            default: return m >> $urandom_range(40, 4);
        endcase
    endfunction

    function automatic operand_pair_t random_pair();
        logic [MAG_W-1:0]   first_mag;
        logic [MAG_W-1:0]   second_mag;
        logic [SCALE_W-1:0] first_scale;
        logic [SCALE_W-1:0] second_scale;
        first_mag    = random_mag();
        second_mag   = random_mag();
        first_scale  = SCALE_W'($urandom_range(28));
        second_scale = SCALE_W'($urandom_range(28));
        case ($urandom_range(9))
            0: second_scale = first_scale;
            1:
            begin
                first_scale  = SCALE_W'($urandom_range(31));
                second_scale = SCALE_W'($urandom_range(31));
            end
            2:
            begin
                // last digit five on both sides, so the first division is a tie
                first_mag  = first_mag - first_mag % 10 + 5;
                second_mag = second_mag - second_mag % 10 + 5;
            end
            default: ;
        endcase
        return make_pair(first_mag, first_scale, second_mag, second_scale);
    endfunction

    task automatic add_row(input logic [MAG_W-1:0] first_mag,
                           input logic [SCALE_W-1:0] first_scale,
                           input logic [MAG_W-1:0] second_mag,
                           input logic [SCALE_W-1:0] second_scale,
                           input bit typed,
                           input logic [MAG_W-1:0] exp_first,
                           input logic [MAG_W-1:0] exp_second,
                           input logic [SCALE_W-1:0] exp_scale);
        stimulus_row_t row;
        row.operands = make_pair(first_mag, first_scale, second_mag, second_scale);
        row.typed    = typed;
        row.result   = make_aligned(exp_first, exp_second, exp_scale);
        directed_rows.push_back(row);
    endtask

    task automatic drive_item(input operand_pair_t op, input bit typed,
                              input aligned_pair_t typed_result);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, op.second_scale, op.second_high, op.second_low,
                     op.first_scale, op.first_high, op.first_low};
        do
            @(posedge clk);
        while (!s_tready);
        if (typed)
            pending_alignments.push_back(typed_result);
        else
            pending_alignments.push_back(align_scales(op));
    endtask

    task automatic run_random(input int count);
        aligned_pair_t unused;
        unused = make_aligned('0, '0, '0);
        repeat (count)
            drive_item(random_pair(), 1'b0, unused);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_alignments.size() != 0);
    endtask

    task automatic note_mismatch(input string field, input logic [MAG_W-1:0] expected,
                                 input logic [MAG_W-1:0] actual);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field,
                     expected, actual);
    endtask

    task automatic check_result(input logic [dsa_pkg::OUT_W-1:0] data);
        aligned_pair_t got;
        aligned_pair_t want;
        got.first_low    = data[63:0];
        got.first_high   = data[95:64];
        got.second_low   = data[159:96];
        got.second_high  = data[191:160];
        got.common_scale = data[196:192];
        if (pending_alignments.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: result transfer with nothing expected: %h", $realtime, data);
            return;
        end
        want = pending_alignments.pop_front();
        if (got.first_low != want.first_low)
            note_mismatch("out_first_low", want.first_low, got.first_low);
        if (got.first_high != want.first_high)
            note_mismatch("out_first_high", want.first_high, got.first_high);
        if (got.second_low != want.second_low)
            note_mismatch("out_second_low", want.second_low, got.second_low);
        if (got.second_high != want.second_high)
            note_mismatch("out_second_high", want.second_high, got.second_high);
        if (got.common_scale != want.common_scale)
            note_mismatch("common_scale", want.common_scale, got.common_scale);
    endtask

    // Result side: check, then choose ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(m_tdata);
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [MAG_W-1:0] all_ones;
        logic [MAG_W-1:0] ten_pow_28;
        all_ones   = '1;
        ten_pow_28 = 96'h204F_CE5E_3E25_0261_1000_0000;

        // first mag, scale | second mag, scale | typed | result first, second, scale
        add_row('0,        0,  '0,       0,  1, '0,         '0,       0);
        add_row(all_ones,  28, all_ones, 28, 1, all_ones,   all_ones, 28);
        add_row(all_ones,  31, all_ones, 31, 1, all_ones,   all_ones, 31);
        add_row(96'd1,     0,  '0,       28, 1, ten_pow_28, '0,       28);
        add_row(96'h0123_4567_89AB_CDEF_0F1E_2D3C, 7, 96'h8000_0000_0000_0000_0000_0001, 7,
                1, 96'h0123_4567_89AB_CDEF_0F1E_2D3C, 96'h8000_0000_0000_0000_0000_0001, 7);
        // ties on the dropped digit: even kept digit stays, odd one rounds up
        add_row(all_ones,  0,  96'd25,   1,  1, all_ones,   96'd2,    0);
        add_row(all_ones,  0,  96'd35,   1,  1, all_ones,   96'd4,    0);
        add_row(96'd26,    1,  all_ones, 0,  0, '0, '0, 0);
        add_row(96'd24,    1,  all_ones, 0,  0, '0, '0, 0);
        add_row(all_ones,  0,  all_ones, 1,  0, '0, '0, 0);
        add_row(all_ones,  0,  '0,       28, 0, '0, '0, 0);
        add_row('0,        28, all_ones, 0,  0, '0, '0, 0);
        add_row(96'd1,     31, 96'd1,    0,  0, '0, '0, 0);
        add_row(96'd7,     29, 96'd123456789, 30, 0, '0, '0, 0);
        add_row(96'h1_0000_0000_0000_0000, 0, 96'h8000_0000_0000_0000_0000_0000, 20,
                0, '0, '0, 0);
        add_row(96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFF9, 2, all_ones, 0, 0, '0, '0, 0);
        add_row(96'h033B_2E3C_9FD0_803C_E800_0000, 0, 96'd5, 3, 0, '0, '0, 0);
        add_row(96'd15,    1,  '0,       0,  0, '0, '0, 0);
        add_row(96'h0000_0009_FFFF_FFFF_FFFF_FFFF, 0, 96'h0000_0000_FFFF_FFFF_0000_0000, 31,
                0, '0, '0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 16;
        recv_idle_pct = 88;
        foreach (directed_rows[i])
            drive_item(directed_rows[i].operands, directed_rows[i].typed,
                       directed_rows[i].result);
        run_random(RANDOM_PER_RUN);
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct = 16;
        run_random(RANDOM_PER_RUN);
        wait_drained();

        // no idling; result side holds off at first so the input backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_left = HOLD_OFF;
        @(posedge clk);
        run_random(RANDOM_PER_RUN);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_alignments.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dsa_pkg.sv
rtl/dsa_alu.sv
rtl/decimal_scale_align_unit.sv
rtl/dsa_checker.sv
verif/tb_decimal_scale_align_unit.sv
